@@ rtl/ulfd_pkg.sv @@
// Shared types and constants for the lenient UTF-8 decoder.
`default_nettype none

package ulfd_pkg;

    localparam int unsigned CP_W        = 21;
    localparam int unsigned MAX_RES     = 4;
    localparam int unsigned RES_IDX_W   = 2;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [7:0] MASK_HI1  = 8'h80;
    localparam logic [7:0] MASK_HI2  = 8'hC0;
    localparam logic [7:0] MASK_HI3  = 8'hE0;
    localparam logic [7:0] MASK_HI4  = 8'hF0;
    localparam logic [7:0] MASK_HI5  = 8'hF8;
    localparam logic [7:0] PAT_CONT  = 8'h80;
    localparam logic [7:0] PAT_LEAD2 = 8'hC0;
    localparam logic [7:0] PAT_LEAD3 = 8'hE0;
    localparam logic [7:0] PAT_LEAD4 = 8'hF0;
    localparam logic [7:0] PAY_LEAD2 = 8'h1F;
    localparam logic [7:0] PAY_LEAD3 = 8'h0F;
    localparam logic [7:0] PAY_LEAD4 = 8'h07;
    localparam logic [7:0] PAY_CONT  = 8'h3F;

    // continuation bytes still needed by the open sequence
    localparam logic [1:0] NEED_NONE = 2'd0;
    localparam logic [1:0] NEED_ONE  = 2'd1;
    localparam logic [1:0] NEED_TWO  = 2'd2;
    localparam logic [1:0] NEED_THREE = 2'd3;

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            raw;
    } t_res;

    // all results caused by one input item
    typedef struct packed {
        t_res [MAX_RES-1:0]   res;
        logic [RES_IDX_W-1:0] last_idx;
        logic                 end_flag;
    } t_job;

endpackage

`default_nettype wire

@@ rtl/ulfd_front.sv @@
// Front end: accepts bytes, tracks the open sequence and builds the result list per item.
`default_nettype none

module ulfd_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [7:0]    i_byte_in,
    input  wire logic          i_string_end,
    input  wire logic          i_q_full,
    output logic               o_push,
    output ulfd_pkg::t_job     o_job
);

    logic [7:0] r_lead, n_lead;
    logic [1:0] r_need, n_need;
    logic [1:0] r_have, n_have;
    logic [7:0] r_c0, n_c0;
    logic [7:0] r_c1, n_c1;

    logic           accept;
    logic           is_cont;
    logic [2:0]     res_n;
    ulfd_pkg::t_job job;

    assign accept  = i_valid && !i_q_full;
    assign is_cont = (i_byte_in & ulfd_pkg::MASK_HI2) == ulfd_pkg::PAT_CONT;

    always_comb begin
        job    = '0;
        res_n  = 3'd0;
        n_lead = r_lead;
        n_need = r_need;
        n_have = r_have;
        n_c0   = r_c0;
        n_c1   = r_c1;

        // broken sequence: dump what was buffered
        if (r_need != ulfd_pkg::NEED_NONE && !is_cont) begin
            job.res[res_n[1:0]] = '{cp: 21'(r_lead), raw: 1'b1};
            res_n = res_n + 3'd1;
            if (r_have >= 2'd1) begin
                job.res[res_n[1:0]] = '{cp: 21'(r_c0), raw: 1'b1};
                res_n = res_n + 3'd1;
            end
            if (r_have >= 2'd2) begin
                job.res[res_n[1:0]] = '{cp: 21'(r_c1), raw: 1'b1};
                res_n = res_n + 3'd1;
            end
            n_need = ulfd_pkg::NEED_NONE;
            n_have = 2'd0;
        end

        if (r_need == ulfd_pkg::NEED_NONE || !is_cont) begin
            if ((i_byte_in & ulfd_pkg::MASK_HI1) == 8'h00) begin
                job.res[res_n[1:0]] = '{cp: 21'(i_byte_in), raw: 1'b0};
                res_n = res_n + 3'd1;
            end else if ((i_byte_in & ulfd_pkg::MASK_HI3) == ulfd_pkg::PAT_LEAD2) begin
                n_lead = i_byte_in;
                n_need = ulfd_pkg::NEED_ONE;
                n_have = 2'd0;
            end else if ((i_byte_in & ulfd_pkg::MASK_HI4) == ulfd_pkg::PAT_LEAD3) begin
                n_lead = i_byte_in;
                n_need = ulfd_pkg::NEED_TWO;
                n_have = 2'd0;
            end else if ((i_byte_in & ulfd_pkg::MASK_HI5) == ulfd_pkg::PAT_LEAD4) begin
                n_lead = i_byte_in;
                n_need = ulfd_pkg::NEED_THREE;
                n_have = 2'd0;
            end else begin
                job.res[res_n[1:0]] = '{cp: 21'(i_byte_in), raw: 1'b1};
                res_n = res_n + 3'd1;
            end
        end else if ({1'b0, r_have} + 3'd1 >= {1'b0, r_need}) begin
            case (r_need)
                ulfd_pkg::NEED_ONE: begin
                    job.res[res_n[1:0]].cp = {10'd0, r_lead[4:0],
                                              i_byte_in[5:0]};
                end
                ulfd_pkg::NEED_TWO: begin
                    job.res[res_n[1:0]].cp = {5'd0, r_lead[3:0], r_c0[5:0],
                                              i_byte_in[5:0]};
                end
                default: begin
                    job.res[res_n[1:0]].cp = {r_lead[2:0], r_c0[5:0], r_c1[5:0],
                                              i_byte_in[5:0]};
                end
            endcase
            job.res[res_n[1:0]].raw = 1'b0;
            res_n  = res_n + 3'd1;
            n_need = ulfd_pkg::NEED_NONE;
            n_have = 2'd0;
        end else begin
            if (r_have[0] == 1'b0) begin
                n_c0 = i_byte_in;
            end else begin
                n_c1 = i_byte_in;
            end
            n_have = r_have + 2'd1;
        end

        // string ends with a sequence still open
        if (i_string_end && n_need != ulfd_pkg::NEED_NONE) begin
            job.res[res_n[1:0]] = '{cp: 21'(n_lead), raw: 1'b1};
            res_n = res_n + 3'd1;
            if (n_have >= 2'd1) begin
                job.res[res_n[1:0]] = '{cp: 21'(n_c0), raw: 1'b1};
                res_n = res_n + 3'd1;
            end
            if (n_have >= 2'd2) begin
                job.res[res_n[1:0]] = '{cp: 21'(n_c1), raw: 1'b1};
                res_n = res_n + 3'd1;
            end
            n_need = ulfd_pkg::NEED_NONE;
            n_have = 2'd0;
        end

        job.last_idx = res_n[1:0] - 2'd1;
        job.end_flag = i_string_end;
    end

    assign o_push = accept && (res_n != 3'd0);
    assign o_job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead <= 8'd0;
            r_need <= ulfd_pkg::NEED_NONE;
            r_have <= 2'd0;
        end else if (accept) begin
            r_lead <= n_lead;
            r_need <= n_need;
            r_have <= n_have;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_c0 <= n_c0;
            r_c1 <= n_c1;
        end
    end

endmodule

`default_nettype wire

@@ rtl/ulfd_queue.sv @@
// Short job queue between front end and output sequencer.
`default_nettype none

module ulfd_queue #(
    parameter int unsigned DEPTH = ulfd_pkg::QUEUE_DEPTH
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_push,
    input  wire ulfd_pkg::t_job           i_job,
    input  wire logic                     i_pop,
    output logic                          o_full,
    output logic                          o_nonempty,
    output ulfd_pkg::t_job                o_job,
    output logic [$clog2(DEPTH+1)-1:0]    o_count
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    ulfd_pkg::t_job r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push, do_pop;

    assign o_full     = r_count == CNT_W'(DEPTH);
    assign o_nonempty = r_count != '0;
    assign o_job      = r_mem[r_rd_ptr];
    assign o_count    = r_count;
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && o_nonempty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/ulfd_back.sv @@
// Output sequencer: walks the result list of each job into the output register.
`default_nettype none

module ulfd_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_q_nonempty,
    input  wire ulfd_pkg::t_job                i_job,
    output logic                               o_pop,
    input  wire logic                          i_stall,
    output logic                               o_valid,
    output logic [ulfd_pkg::CP_W-1:0]          o_code_point,
    output logic                               o_raw_fallback,
    output logic                               o_run_last,
    output logic                               o_text_last
);

    logic                                r_valid;
    logic [ulfd_pkg::RES_IDX_W-1:0]      r_idx, n_idx;
    logic [ulfd_pkg::CP_W-1:0]           r_cp;
    logic                                r_raw, r_run_last, r_text_last;

    logic advance, take, is_last;

    assign advance = !r_valid || !i_stall;
    assign take    = advance && i_q_nonempty;
    assign is_last = r_idx == i_job.last_idx;
    assign o_pop   = take && is_last;
    assign n_idx   = is_last ? '0 : r_idx + ulfd_pkg::RES_IDX_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (advance) begin
            r_valid <= i_q_nonempty;
            if (take) begin
                r_idx <= n_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cp        <= i_job.res[r_idx].cp;
            r_raw       <= i_job.res[r_idx].raw;
            r_run_last  <= is_last;
            r_text_last <= is_last && i_job.end_flag;
        end
    end

    assign o_valid        = r_valid;
    assign o_code_point   = r_cp;
    assign o_raw_fallback = r_raw;
    assign o_run_last     = r_run_last;
    assign o_text_last    = r_text_last;

endmodule

`default_nettype wire

@@ rtl/utf8_lenient_decoder.sv @@
// Lenient UTF-8 decoder top level: one byte per item in, code points out.
// Input channel: i_valid / o_stall carry i_byte_in and i_string_end; a byte is
// taken at a rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall carry o_code_point, o_raw_fallback,
// o_run_last and o_text_last; a result leaves at an edge with o_valid high and
// i_stall low. o_run_last marks the last result of an input byte, o_text_last
// the last result of the string.
// Each byte yields zero to four results. A byte is classified in the cycle it
// is taken and its result list goes into a job queue (QUEUE_DEPTH entries) at
// that edge; the output register then loads the results from the queue head one
// by one whenever it is not held by i_stall.
// Throughput: one byte per cycle while each byte gives at most one result and
// i_stall stays low; a byte with several results holds the output register until
// all have left, and the input stalls only once the queue is full.
// A stall on the output side freezes the output register and the queue fills;
// o_stall then rises until an entry drains.
// Reset (i_rst_n low at a clock edge) closes any open sequence and empties the
// queue and the output register.
`default_nettype none

module utf8_lenient_decoder #(
    parameter int unsigned QUEUE_DEPTH = ulfd_pkg::QUEUE_DEPTH
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic [7:0]                i_byte_in,
    input  wire logic                      i_string_end,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output logic [ulfd_pkg::CP_W-1:0]      o_code_point,
    output logic                           o_raw_fallback,
    output logic                           o_run_last,
    output logic                           o_text_last
);

    logic                              q_push, q_pop, q_full, q_nonempty;
    ulfd_pkg::t_job                    q_in_job, q_out_job;
    logic [$clog2(QUEUE_DEPTH+1)-1:0]  q_count;

    ulfd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_byte_in    (i_byte_in),
        .i_string_end (i_string_end),
        .i_q_full     (q_full),
        .o_push       (q_push),
        .o_job        (q_in_job)
    );

    ulfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_job      (q_in_job),
        .i_pop      (q_pop),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_job      (q_out_job),
        .o_count    (q_count)
    );

    ulfd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_nonempty   (q_nonempty),
        .i_job          (q_out_job),
        .o_pop          (q_pop),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_code_point   (o_code_point),
        .o_raw_fallback (o_raw_fallback),
        .o_run_last     (o_run_last),
        .o_text_last    (o_text_last)
    );

    assign o_stall = q_full;

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
        else $error("job queue count beyond depth");

    a_text_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_text_last |-> o_run_last)
        else $error("string end not on last result of a byte");

    a_raw_is_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_raw_fallback |-> o_code_point[ulfd_pkg::CP_W-1:8] == '0)
        else $error("raw fallback wider than a byte");

    a_pop_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_nonempty && !(o_valid && i_stall))
        else $error("job popped while output blocked");

endmodule

`default_nettype wire

@@ sim/utf8_lenient_decoder_checker.sv @@
// Checker for the lenient UTF-8 decoder: predicts code points per byte and compares outputs.
`timescale 1ns / 1ps

module utf8_lenient_decoder_checker (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    input  wire logic                      i_in_stall,
    input  wire logic [7:0]                i_byte_in,
    input  wire logic                      i_string_end,
    input  wire logic                      i_out_valid,
    input  wire logic                      i_out_stall,
    input  wire logic [ulfd_pkg::CP_W-1:0] i_code_point,
    input  wire logic                      i_raw_fallback,
    input  wire logic                      i_run_last,
    input  wire logic                      i_text_last,
    output int                             o_err_count,
    output int                             o_pending
);

    localparam int unsigned CP_W = ulfd_pkg::CP_W;

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            raw;
        logic            run_last;
        logic            text_last;
    } t_cp_rec;

    t_cp_rec expected_cps[$];
    t_cp_rec byte_cps[$];
    t_cp_rec want;
    int      err_count;

    // open sequence
    logic [7:0] seq_lead;
    logic [7:0] seq_cont [2];
    logic [1:0] seq_need;
    logic [1:0] seq_have;

    task automatic emit(input logic [CP_W-1:0] cp, input logic raw);
        t_cp_rec rec;
        rec.cp        = cp;
        rec.raw       = raw;
        rec.run_last  = 1'b0;
        rec.text_last = 1'b0;
        byte_cps.push_back(rec);
    endtask

    task automatic flush_seq();
        if (seq_need != ulfd_pkg::NEED_NONE) begin
            emit(CP_W'(seq_lead), 1'b1);
            for (int i = 0; i < int'(seq_have) && i < 2; i++)
                emit(CP_W'(seq_cont[i]), 1'b1);
            seq_need = ulfd_pkg::NEED_NONE;
            seq_have = '0;
        end
    endtask

    task automatic start_fresh(input logic [7:0] b);
        if ((b & ulfd_pkg::MASK_HI1) == 8'h00) begin
            emit(CP_W'(b), 1'b0);
        end else if ((b & ulfd_pkg::MASK_HI3) == ulfd_pkg::PAT_LEAD2) begin
            seq_lead = b;
            seq_need = ulfd_pkg::NEED_ONE;
            seq_have = '0;
        end else if ((b & ulfd_pkg::MASK_HI4) == ulfd_pkg::PAT_LEAD3) begin
            seq_lead = b;
            seq_need = ulfd_pkg::NEED_TWO;
            seq_have = '0;
        end else if ((b & ulfd_pkg::MASK_HI5) == ulfd_pkg::PAT_LEAD4) begin
            seq_lead = b;
            seq_need = ulfd_pkg::NEED_THREE;
            seq_have = '0;
        end else begin
            emit(CP_W'(b), 1'b1);
        end
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic fin);
        logic [CP_W-1:0] cp;
        t_cp_rec         rec;
        int              n;
        byte_cps.delete();
        if (seq_need == ulfd_pkg::NEED_NONE) begin
            start_fresh(b);
        end else if ((b & ulfd_pkg::MASK_HI2) == ulfd_pkg::PAT_CONT) begin
            if ({1'b0, seq_have} + 3'd1 >= {1'b0, seq_need}) begin
                case (seq_need)
                    ulfd_pkg::NEED_ONE: cp = (CP_W'(seq_lead & ulfd_pkg::PAY_LEAD2) << 6)
                                 | CP_W'(b & ulfd_pkg::PAY_CONT);
                    ulfd_pkg::NEED_TWO: cp = (CP_W'(seq_lead & ulfd_pkg::PAY_LEAD3) << 12)
                                 | (CP_W'(seq_cont[0] & ulfd_pkg::PAY_CONT) << 6)
                                 | CP_W'(b & ulfd_pkg::PAY_CONT);
                    default:  cp = (CP_W'(seq_lead & ulfd_pkg::PAY_LEAD4) << 18)
                                 | (CP_W'(seq_cont[0] & ulfd_pkg::PAY_CONT) << 12)
                                 | (CP_W'(seq_cont[1] & ulfd_pkg::PAY_CONT) << 6)
                                 | CP_W'(b & ulfd_pkg::PAY_CONT);
                endcase
                emit(cp, 1'b0);
                seq_need = ulfd_pkg::NEED_NONE;
                seq_have = '0;
            end else begin
                seq_cont[seq_have[0]] = b;
                seq_have = seq_have + 2'd1;
            end
        end else begin
            // broken sequence: flush, then take the byte as if nothing were open
            flush_seq();
            start_fresh(b);
        end
        if (fin)
            flush_seq();
        n = byte_cps.size();
        for (int i = 0; i < n; i++) begin
            rec           = byte_cps[i];
            rec.run_last  = (i == n - 1);
            rec.text_last = (i == n - 1) && fin;
            expected_cps.push_back(rec);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_cps.delete();
            seq_lead    = '0;
            seq_cont[0] = '0;
            seq_cont[1] = '0;
            seq_need    = ulfd_pkg::NEED_NONE;
            seq_have    = '0;
            err_count   = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_cps.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("%0t: unexpected result cp=%h raw=%b run=%b text=%b",
                                 $realtime, i_code_point, i_raw_fallback, i_run_last,
                                 i_text_last);
                end else begin
                    want = expected_cps.pop_front();
                    if (want.cp !== i_code_point || want.raw !== i_raw_fallback
                            || want.run_last !== i_run_last
                            || want.text_last !== i_text_last) begin
                        err_count++;
                        if (err_count <= 10) begin
                            $write("%0t: mismatch exp cp=%h raw=%b run=%b text=%b",
                                   $realtime, want.cp, want.raw, want.run_last,
                                   want.text_last);
                            $display(" got cp=%h raw=%b run=%b text=%b",
                                     i_code_point, i_raw_fallback, i_run_last,
                                     i_text_last);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                decode_byte(i_byte_in, i_string_end);
        end
        o_err_count <= err_count;
        o_pending   <= expected_cps.size();
    end

endmodule

@@ sim/utf8_lenient_decoder_tb.sv @@
// Testbench top for the lenient UTF-8 decoder: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps

module utf8_lenient_decoder_tb;

    localparam int RANDOM_ITEMS = 126;
    localparam int HOLD_CYCLES  = 100;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_stall;
    logic [7:0]                i_byte_in;
    logic                      i_string_end;
    logic                      o_valid;
    logic                      i_stall;
    logic [ulfd_pkg::CP_W-1:0] o_code_point;
    logic                      o_raw_fallback;
    logic                      o_run_last;
    logic                      o_text_last;

    int err_count;
    int pending_count;
    int sent_count;
    bit idle_on;
    bit hold_request;

    utf8_lenient_decoder u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_byte_in      (i_byte_in),
        .i_string_end   (i_string_end),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_code_point   (o_code_point),
        .o_raw_fallback (o_raw_fallback),
        .o_run_last     (o_run_last),
        .o_text_last    (o_text_last)
    );

    utf8_lenient_decoder_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_byte_in      (i_byte_in),
        .i_string_end   (i_string_end),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_code_point   (o_code_point),
        .i_raw_fallback (o_raw_fallback),
        .i_run_last     (o_run_last),
        .i_text_last    (o_text_last),
        .o_err_count    (err_count),
        .o_pending      (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("utf8_lenient_decoder_tb: done, errors");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] lead_for(input int len);
        logic [7:0] r;
        r = 8'($urandom);
        case (len)
            1:       return {1'b0, r[6:0]};
            2:       return {3'b110, r[4:0]};
            3:       return {4'b1110, r[3:0]};
            default: return {5'b11110, r[2:0]};
        endcase
    endfunction

    function automatic logic [7:0] cont_byte();
        logic [7:0] r;
        r = 8'($urandom);
        return {2'b10, r[5:0]};
    endfunction

    function automatic logic end_flag();
        return ($urandom_range(0, 9) == 0);
    endfunction

    // receiver: random stall runs, plus one long hold-off on request
    initial begin
        int  run_left;
        bit  stalled;
        bit  hold_done;
        run_left  = 0;
        stalled   = 1'b0;
        hold_done = 1'b0;
        i_stall   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                if (run_left == 0) begin
                    stalled  = ($urandom_range(0, 2) == 0);
                    run_left = stalled ? pick_gap() + 1 : $urandom_range(1, 6);
                end
                run_left--;
                i_stall <= idle_on && stalled;
            end
        end
    end

    // starts and returns at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_byte_in    <= b;
        i_string_end <= fin;
        i_valid      <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
        sent_count++;
    endtask

    // mostly well-formed sequences, some truncated ones, some noise
    task automatic send_random_unit();
        int         kind;
        int         len;
        int         ncont;
        logic [7:0] b;
        kind = $urandom_range(0, 99);
        if (kind < 60) begin
            len = $urandom_range(1, 4);
            send_byte(lead_for(len), (len == 1) && end_flag());
            for (int i = 1; i < len; i++)
                send_byte(cont_byte(),
                          (i == len - 1) ? end_flag() : ($urandom_range(0, 29) == 0));
        end else if (kind < 80) begin
            len   = $urandom_range(2, 4);
            ncont = $urandom_range(0, len - 2);
            send_byte(lead_for(len), 1'b0);
            for (int i = 0; i < ncont; i++)
                send_byte(cont_byte(), (i == ncont - 1) && end_flag());
            b = 8'($urandom);
            send_byte(b, end_flag());
        end else begin
            b = 8'($urandom);
            send_byte(b, end_flag());
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_byte_in    = '0;
        i_string_end = 1'b0;
        idle_on      = 1'b1;
        hold_request = 1'b0;
        sent_count   = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // ASCII extremes
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b1);
        // two, three and four byte sequences, the last one the largest code point
        send_byte(8'hC3, 1'b0);
        send_byte(8'hA9, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hAC, 1'b0);
        send_byte(8'hF7, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b1);
        // stray continuation and invalid leads
        send_byte(8'hBF, 1'b0);
        send_byte(8'hF8, 1'b0);
        send_byte(8'hFF, 1'b0);
        // sequence broken by ASCII
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'h41, 1'b0);
        // four byte sequence broken by an invalid lead: four results at once
        send_byte(8'hF0, 1'b0);
        send_byte(8'h90, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        // lead broken by another lead, then string ends mid-sequence
        send_byte(8'hC3, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b1);

        // long receiver hold-off while the sender keeps offering items
        hold_request = 1'b1;
        while (sent_count < 24 + RANDOM_ITEMS) begin
            if (sent_count > 80 && sent_count < 120)
                idle_on = 1'b0;
            else
                idle_on = 1'b1;
            send_random_unit();
        end
        i_valid <= 1'b0;
        idle_on = 1'b0;

        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (err_count == 0 && pending_count == 0)
            $display("utf8_lenient_decoder_tb: done, clean");
        else
            $display("utf8_lenient_decoder_tb: done, errors");
        $finish;
    end

endmodule
